/* rtl/core/thc_pkg.sv */
// Shared types and constants for the temperature and humidity compensation block.
// No dependencies; imported by every module of the block.
package thc_pkg;

    localparam int RAW_W      = 20;
    localparam int VALUE_W    = 18;
    localparam int WORD_W     = 32;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;

    typedef logic signed [WORD_W-1:0] word_t;

    typedef struct packed {
        logic [15:0] t1;
        logic [15:0] t2;
        logic [15:0] t3;
        logic [7:0]  h1;
        logic [15:0] h2;
        logic [7:0]  h3;
        logic [23:0] h4_h5;
        logic [7:0]  h6;
    } thc_cfg_t;

    typedef struct packed {
        logic  en;
        word_t a;
        word_t b;
    } thc_mul_req_t;

    typedef struct packed {
        logic               valid;
        logic               kind;
        logic [VALUE_W-1:0] value;
    } thc_res_t;

endpackage

/* rtl/core/temp_humidity_compensation.sv */
// Top level of the temperature and humidity compensation block: calibration
// registers, output register, sequencer and shared multiplier.
// Depends on thc_pkg, thc_ctrl and thc_mul.
//
// Usage:
//   Calibration registers are written on the cfg_ channel (index 0..7, data
//   masked to the register width, higher indexes ignored); cfg_ready is
//   always high. Write them only while no item is in flight.
//   Input items (s_func, s_raw_sample) enter on the s_ channel; s_func 0 is a
//   temperature sample, 1 a humidity sample. Each item gives one result item
//   (m_kind, m_value) on the m_ channel.
//   Temperature items take 3 passes through the shared multiplier, humidity
//   items 8 passes; each pass is an issue state and a writeback state, with a
//   set-up state before the first pass and a hand-over state after the last.
//   s_ready is low while an item is being worked on, so a new item is taken
//   only after the previous result has been handed over to the output register.
//   A finished result waits in the output register; the next item is taken
//   meanwhile, and its result holds in the sequencer until the register frees.
//   Reset clears all calibration registers, the fine temperature and the
//   output valid flag; a humidity item before any temperature item uses zero.
module temp_humidity_compensation (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_func,
    input  logic [thc_pkg::RAW_W-1:0]           s_raw_sample,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_kind,
    output logic signed [thc_pkg::VALUE_W-1:0]  m_value,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [thc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [thc_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import thc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_T1    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_T2    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_T3    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_H1    = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_H2    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_H3    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_H4_H5 = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_H6    = 4'd7;

    thc_cfg_t           cfg_reg;
    thc_mul_req_t       mul_req;
    word_t              mul_prod;
    thc_res_t           res;
    logic               res_ready;
    logic               m_valid_reg;
    logic               m_kind_reg;
    logic [VALUE_W-1:0] m_value_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_T1:    cfg_reg.t1    <= cfg_data[15:0];
                REG_T2:    cfg_reg.t2    <= cfg_data[15:0];
                REG_T3:    cfg_reg.t3    <= cfg_data[15:0];
                REG_H1:    cfg_reg.h1    <= cfg_data[7:0];
                REG_H2:    cfg_reg.h2    <= cfg_data[15:0];
                REG_H3:    cfg_reg.h3    <= cfg_data[7:0];
                REG_H4_H5: cfg_reg.h4_h5 <= cfg_data[23:0];
                REG_H6:    cfg_reg.h6    <= cfg_data[7:0];
                default:   cfg_reg       <= cfg_reg;
            endcase
        end
    end

    thc_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_func   (s_func),
        .in_raw    (s_raw_sample),
        .cfg       (cfg_reg),
        .mul_req   (mul_req),
        .mul_prod  (mul_prod),
        .res       (res),
        .res_ready (res_ready)
    );

    thc_mul u_mul (
        .aclk (aclk),
        .req  (mul_req),
        .prod (mul_prod)
    );

    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res.valid;
            if (res.valid) begin
                m_kind_reg  <= res.kind;
                m_value_reg <= res.value;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_kind  = m_kind_reg;
    assign m_value = $signed(m_value_reg);

endmodule

/* rtl/core/thc_mul.sv */
// Shared 32 x 32 multiplier keeping the low 32 bits, product registered.
// Depends on thc_pkg.
module thc_mul (
    input  logic                 aclk,
    input  thc_pkg::thc_mul_req_t req,
    output thc_pkg::word_t       prod
);
    import thc_pkg::*;

    word_t prod_reg;

    always_ff @(posedge aclk) begin
        if (req.en) begin
            prod_reg <= req.a * req.b;
        end
    end

    assign prod = prod_reg;

endmodule

/* rtl/core/thc_ctrl.sv */
// Sequencer and working registers for temperature and humidity compensation.
// Drives the shared multiplier in thc_mul; depends on thc_pkg.
module thc_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       in_func,
    input  logic [thc_pkg::RAW_W-1:0]  in_raw,
    input  thc_pkg::thc_cfg_t          cfg,
    output thc_pkg::thc_mul_req_t      mul_req,
    input  thc_pkg::word_t             mul_prod,
    output thc_pkg::thc_res_t          res,
    input  logic                       res_ready
);
    import thc_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PREP = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_WB   = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    localparam logic [3:0] OP_T_V1   = 4'd0;
    localparam logic [3:0] OP_T_DD   = 4'd1;
    localparam logic [3:0] OP_T_V2   = 4'd2;
    localparam logic [3:0] OP_H_H5V  = 4'd3;
    localparam logic [3:0] OP_H_H6V  = 4'd4;
    localparam logic [3:0] OP_H_H3V  = 4'd5;
    localparam logic [3:0] OP_H_BC   = 4'd6;
    localparam logic [3:0] OP_H_H2   = 4'd7;
    localparam logic [3:0] OP_H_AB   = 4'd8;
    localparam logic [3:0] OP_H_QQ   = 4'd9;
    localparam logic [3:0] OP_H_H1   = 4'd10;

    localparam word_t V_OFFSET = 32'sd76800;
    localparam word_t K_16384  = 32'sd16384;
    localparam word_t K_32768  = 32'sd32768;
    localparam word_t K_2P21   = 32'sd2097152;
    localparam word_t K_8192   = 32'sd8192;
    localparam word_t HUM_MAX  = 32'sd419430400;
    localparam word_t K_128    = 32'sd128;
    localparam word_t T_MAX    = 32'sd32767;
    localparam word_t T_MIN    = -32'sd32768;

    logic [2:0]         state_reg, state_next;
    logic [3:0]         op_reg;
    logic               func_reg;
    logic [RAW_W-1:0]   raw_reg;
    word_t              fine_reg;
    word_t              v_reg;
    word_t              w0_reg, w1_reg, w2_reg;

    word_t t1_z, t2_s, t3_s, h1_z, h2_s, h3_z, h4_s, h5_s, h6_s;
    word_t t_d, f5, tq, hx;
    logic [15:0] t_sat;

    assign t1_z = $signed({16'd0, cfg.t1});
    assign t2_s = $signed({{16{cfg.t2[15]}}, cfg.t2});
    assign t3_s = $signed({{16{cfg.t3[15]}}, cfg.t3});
    assign h1_z = $signed({24'd0, cfg.h1});
    assign h2_s = $signed({{16{cfg.h2[15]}}, cfg.h2});
    assign h3_z = $signed({24'd0, cfg.h3});
    assign h4_s = $signed({{20{cfg.h4_h5[23]}}, cfg.h4_h5[23:12]});
    assign h5_s = $signed({{20{cfg.h4_h5[11]}}, cfg.h4_h5[11:0]});
    assign h6_s = $signed({{24{cfg.h6[7]}}, cfg.h6});
    assign t_d  = $signed({16'd0, raw_reg[19:4]}) - t1_z;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_valid) state_next = ST_PREP;
            ST_PREP: state_next = ST_MUL;
            ST_MUL:  state_next = ST_WB;
            ST_WB: begin
                if (op_reg == OP_T_V2 || op_reg == OP_H_H1) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_DONE: if (res_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        mul_req.en = (state_reg == ST_MUL);
        mul_req.a  = '0;
        mul_req.b  = '0;
        unique case (op_reg)
            OP_T_V1: begin
                mul_req.a = $signed({15'd0, raw_reg[19:3]}) - $signed({15'd0, cfg.t1, 1'b0});
                mul_req.b = t2_s;
            end
            OP_T_DD: begin
                mul_req.a = t_d;
                mul_req.b = t_d;
            end
            OP_T_V2: begin
                mul_req.a = w1_reg;
                mul_req.b = t3_s;
            end
            OP_H_H5V: begin
                mul_req.a = h5_s;
                mul_req.b = v_reg;
            end
            OP_H_H6V: begin
                mul_req.a = v_reg;
                mul_req.b = h6_s;
            end
            OP_H_H3V: begin
                mul_req.a = v_reg;
                mul_req.b = h3_z;
            end
            OP_H_BC: begin
                mul_req.a = w1_reg;
                mul_req.b = w2_reg;
            end
            OP_H_H2: begin
                mul_req.a = w1_reg;
                mul_req.b = h2_s;
            end
            OP_H_AB: begin
                mul_req.a = w0_reg;
                mul_req.b = w1_reg;
            end
            OP_H_QQ: begin
                mul_req.a = w0_reg >>> 15;
                mul_req.b = w0_reg >>> 15;
            end
            OP_H_H1: begin
                mul_req.a = w1_reg;
                mul_req.b = h1_z;
            end
            default: begin
                mul_req.a = '0;
                mul_req.b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fine_reg  <= '0;
            op_reg    <= OP_T_V1;
            func_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_valid) begin
                        func_reg <= in_func;
                        raw_reg  <= in_raw;
                    end
                end
                ST_PREP: begin
                    v_reg  <= fine_reg - V_OFFSET;
                    op_reg <= func_reg ? OP_H_H5V : OP_T_V1;
                end
                ST_MUL: begin
                end
                ST_WB: begin
                    if (op_reg != OP_T_V2 && op_reg != OP_H_H1) begin
                        op_reg <= op_reg + 4'd1;
                    end
                    case (op_reg)
                        OP_T_V1:  w0_reg <= mul_prod >>> 11;
                        OP_T_DD:  w1_reg <= mul_prod >>> 12;
                        OP_T_V2:  fine_reg <= w0_reg + (mul_prod >>> 14);
                        OP_H_H5V: w0_reg <= ($signed({2'd0, raw_reg[15:0], 14'd0})
                                             - $signed({h4_s[11:0], 20'd0})
                                             - mul_prod + K_16384) >>> 15;
                        OP_H_H6V: w1_reg <= mul_prod >>> 10;
                        OP_H_H3V: w2_reg <= (mul_prod >>> 11) + K_32768;
                        OP_H_BC:  w1_reg <= (mul_prod >>> 10) + K_2P21;
                        OP_H_H2:  w1_reg <= (mul_prod + K_8192) >>> 14;
                        OP_H_AB:  w0_reg <= mul_prod;
                        OP_H_QQ:  w1_reg <= mul_prod >>> 7;
                        OP_H_H1:  w0_reg <= w0_reg - (mul_prod >>> 4);
                        default:  w0_reg <= w0_reg;
                    endcase
                end
                ST_DONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        f5 = (fine_reg <<< 2) + fine_reg + K_128;
        tq = f5 >>> 8;
        if (tq > T_MAX) begin
            t_sat = T_MAX[15:0];
        end else if (tq < T_MIN) begin
            t_sat = T_MIN[15:0];
        end else begin
            t_sat = tq[15:0];
        end
        if (w0_reg[31]) begin
            hx = '0;
        end else if (w0_reg > HUM_MAX) begin
            hx = HUM_MAX;
        end else begin
            hx = w0_reg;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign res.valid = (state_reg == ST_DONE);
    assign res.kind  = func_reg;
    assign res.value = func_reg ? hx[29:12] : {{2{t_sat[15]}}, t_sat};

`ifndef SYNTHESIS
    a_mul_then_wb: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_MUL |=> state_reg == ST_WB)
        else $error("multiply not followed by writeback");
    a_temp_ops: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL && !func_reg) |-> op_reg <= OP_T_V2)
        else $error("temperature item ran a humidity step");
    a_hum_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (res.valid && res.kind) |-> (!res.value[17] && res.value <= 18'd102400))
        else $error("humidity result out of range");
    a_temp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (res.valid && !res.kind) |-> (res.value[17] == res.value[15]
                                      && res.value[16] == res.value[15]))
        else $error("temperature result not saturated");
    a_fine_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WB && func_reg) |=> $stable(fine_reg))
        else $error("humidity item changed fine temperature");
`endif

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
// Self-checking bench for temp_humidity_compensation: directed rows, then random
// calibration sets and samples under varied handshake idling, checked against a
// built-in predictor of the compensation arithmetic. Depends on thc_pkg and the RTL.
module testbench;

    import thc_pkg::*;

    localparam int RESET_CYCLES    = 10;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 75;
    localparam int PRESSURE_PHASE  = 4;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int STALL_LIMIT     = 2000;
    localparam int TAIL_CYCLES     = 40;
    localparam int CAL_REGS        = 8;
    localparam int DIRECTED_ROWS   = 43;

    typedef logic [WORD_W-1:0] uword_t;
    typedef logic signed [VALUE_W-1:0] value_t;

    localparam uword_t FINE_BIAS = 32'd76800;
    localparam uword_t HUM_CLAMP = 32'd419430400;

    typedef enum logic {FUNC_TEMP = 1'b0, FUNC_HUM = 1'b1} func_e;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_T1       = 0,
        REG_T2       = 1,
        REG_T3       = 2,
        REG_H1       = 3,
        REG_H2       = 4,
        REG_H3       = 5,
        REG_H4_H5    = 6,
        REG_H6       = 7,
        REG_SPARE_LO = 8,
        REG_SPARE_HI = 15
    } cal_reg_e;

    typedef enum logic {ROW_SAMPLE, ROW_CAL} row_op_e;

    typedef struct packed {
        row_op_e               op;
        func_e                 func;
        cal_reg_e              addr;
        logic [CFG_DATA_W-1:0] data;
        logic                  fixed;
        value_t                fixed_value;
    } script_row_t;

    typedef struct packed {
        logic   kind;
        value_t value;
    } reading_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_func;
    logic [RAW_W-1:0]      s_raw_sample;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_kind;
    value_t                m_value;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    thc_cfg_t cal;
    uword_t   fine_t;
    reading_t awaited[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int holds_served   = 0;
    int mismatch_count = 0;
    int checked_count  = 0;
    int temp_items     = 0;
    int hum_items      = 0;
    int cal_sets       = 0;

    script_row_t directed_rows [DIRECTED_ROWS] = '{
        '{ROW_SAMPLE, FUNC_HUM,  REG_T1,       24'h0FFFFF, 1'b1, 18'sd0},
        '{ROW_SAMPLE, FUNC_TEMP, REG_T1,       24'h0FFFFF, 1'b1, 18'sd0},
        '{ROW_SAMPLE, FUNC_TEMP, REG_T1,       24'h000000, 1'b1, 18'sd0},
        '{ROW_SAMPLE, FUNC_HUM,  REG_T1,       24'h000000, 1'b1, 18'sd0},
        '{ROW_CAL,    FUNC_TEMP, REG_T1,       24'h006B70, 1'b0, 18'sd0},
        '{ROW_CAL,    FUNC_TEMP, REG_T2,       24'h006743, 1'b0, 18'sd0},
        '{ROW_CAL,    FUNC_TEMP, REG_T3,       24'h00FC18, 1'b0, 18'sd0},
        '{ROW_CAL,    FUNC_TEMP, REG_H1,       24'h00004B, 1'b0, 18'sd0},
        '{ROW_CAL,    FUNC_TEMP, REG_H2,       24'h00016A, 1'b0, 18'sd0},
        '{ROW_CAL,    FUNC_TEMP, REG_H3,       24'h000000, 1'b0, 18'sd0},
        '{ROW_CAL,    FUNC_TEMP, REG_H4_H5,    24'h139032, 1'b0, 18'sd0},
        '{ROW_CAL,    FUNC_TEMP, REG_H6,       24'h00001E, 1'b0, 18'sd0},
        '{ROW_CAL,    FUNC_TEMP, REG_SPARE_HI, 24'hFFFFFF, 1'b0, 18'sd0},
        '{ROW_SAMPLE, FUNC_TEMP, REG_T1,       24'h07EED0, 1'b0, 18'sd0},
        '{ROW_SAMPLE, FUNC_HUM,  REG_T1,       24'h007530, 1'b0, 18'sd0},
        '{ROW_SAMPLE, FUNC_HUM,  REG_T1,       24'h0F7530, 1'b0, 18'sd0},
        '{ROW_SAMPLE, FUNC_HUM,  REG_T1,       24'h00FFFF, 1'b0, 18'sd0},
        '{ROW_SAMPLE, FUNC_HUM,  REG_T1,       24'h000000, 1'b0, 18'sd0},
        '{ROW_SAMPLE, FUNC_TEMP, REG_T1,       24'h000000, 1'b0, 18'sd0},
        '{ROW_CAL,    FUNC_TEMP, REG_T1,       24'h00FFFF, 1'b0, 18'sd0},
        '{ROW_CAL,    FUNC_TEMP, REG_T2,       24'h007FFF, 1'b0, 18'sd0},
        '{ROW_CAL,    FUNC_TEMP, REG_T3,       24'h008000, 1'b0, 18'sd0},
        '{ROW_CAL,    FUNC_TEMP, REG_H1,       24'h0000FF, 1'b0, 18'sd0},
        '{ROW_CAL,    FUNC_TEMP, REG_H2,       24'h008000, 1'b0, 18'sd0},
        '{ROW_CAL,    FUNC_TEMP, REG_H3,       24'h0000FF, 1'b0, 18'sd0},
        '{ROW_CAL,    FUNC_TEMP, REG_H4_H5,    24'hFFFFFF, 1'b0, 18'sd0},
        '{ROW_CAL,    FUNC_TEMP, REG_H6,       24'h000080, 1'b0, 18'sd0},
        '{ROW_SAMPLE, FUNC_TEMP, REG_T1,       24'h0FFFFF, 1'b0, 18'sd0},
        '{ROW_SAMPLE, FUNC_HUM,  REG_T1,       24'h00FFFF, 1'b0, 18'sd0},
        '{ROW_SAMPLE, FUNC_TEMP, REG_T1,       24'h000000, 1'b0, 18'sd0},
        '{ROW_SAMPLE, FUNC_HUM,  REG_T1,       24'h000000, 1'b0, 18'sd0},
        '{ROW_CAL,    FUNC_TEMP, REG_T1,       24'h000000, 1'b0, 18'sd0},
        '{ROW_CAL,    FUNC_TEMP, REG_T2,       24'h008000, 1'b0, 18'sd0},
        '{ROW_CAL,    FUNC_TEMP, REG_T3,       24'h007FFF, 1'b0, 18'sd0},
        '{ROW_CAL,    FUNC_TEMP, REG_H1,       24'h000000, 1'b0, 18'sd0},
        '{ROW_CAL,    FUNC_TEMP, REG_H2,       24'h007FFF, 1'b0, 18'sd0},
        '{ROW_CAL,    FUNC_TEMP, REG_H3,       24'h000000, 1'b0, 18'sd0},
        '{ROW_CAL,    FUNC_TEMP, REG_H4_H5,    24'h800800, 1'b0, 18'sd0},
        '{ROW_CAL,    FUNC_TEMP, REG_H6,       24'h00007F, 1'b0, 18'sd0},
        '{ROW_SAMPLE, FUNC_TEMP, REG_T1,       24'h080000, 1'b0, 18'sd0},
        '{ROW_SAMPLE, FUNC_HUM,  REG_T1,       24'h0FFFFF, 1'b0, 18'sd0},
        '{ROW_SAMPLE, FUNC_HUM,  REG_T1,       24'h000000, 1'b0, 18'sd0},
        '{ROW_SAMPLE, FUNC_TEMP, REG_T1,       24'h0FFFFF, 1'b0, 18'sd0}
    };

    temp_humidity_compensation i_dut (.*);

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic uword_t shr_arith(input uword_t x, input int n);
        return uword_t'($signed(x) >>> n);
    endfunction

    function automatic value_t predict_temperature(input logic [RAW_W-1:0] raw,
                                                   output uword_t fine);
        uword_t r, t1, t2, t3, v1, d, v2, scaled;
        r  = {12'h000, raw};
        t1 = {16'h0000, cal.t1};
        t2 = {{16{cal.t2[15]}}, cal.t2};
        t3 = {{16{cal.t3[15]}}, cal.t3};
        v1 = shr_arith(((r >> 3) - (t1 << 1)) * t2, 11);
        d  = (r >> 4) - t1;
        v2 = shr_arith(shr_arith(d * d, 12) * t3, 14);
        fine   = v1 + v2;
        scaled = shr_arith(fine * 32'd5 + 32'd128, 8);
        if ($signed(scaled) > 32'sd32767)
            return value_t'(32767);
        if ($signed(scaled) < -32'sd32768)
            return value_t'(-32768);
        return value_t'(scaled[VALUE_W-1:0]);
    endfunction

    function automatic value_t predict_humidity(input logic [RAW_W-1:0] raw,
                                                input uword_t fine);
        uword_t h, h1, h2, h3, h4, h5, h6, v, a, b, c, x, q;
        h  = {16'h0000, raw[15:0]};
        h1 = {24'h000000, cal.h1};
        h2 = {{16{cal.h2[15]}}, cal.h2};
        h3 = {24'h000000, cal.h3};
        h4 = {{20{cal.h4_h5[23]}}, cal.h4_h5[23:12]};
        h5 = {{20{cal.h4_h5[11]}}, cal.h4_h5[11:0]};
        h6 = {{24{cal.h6[7]}}, cal.h6};
        v  = fine - FINE_BIAS;
        a  = shr_arith((h << 14) - (h4 << 20) - h5 * v + 32'd16384, 15);
        b  = shr_arith(v * h6, 10);
        c  = shr_arith(v * h3, 11) + 32'd32768;
        b  = shr_arith(b * c, 10) + 32'd2097152;
        b  = shr_arith(b * h2 + 32'd8192, 14);
        x  = a * b;
        q  = shr_arith(x, 15);
        x  = x - shr_arith(shr_arith(q * q, 7) * h1, 4);
        if (x[WORD_W-1])
            x = '0;
        else if (x > HUM_CLAMP)
            x = HUM_CLAMP;
        return value_t'(x[VALUE_W+11:12]);
    endfunction

    function automatic void apply_cal(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_T1:    cal.t1    = data[15:0];
            REG_T2:    cal.t2    = data[15:0];
            REG_T3:    cal.t3    = data[15:0];
            REG_H1:    cal.h1    = data[7:0];
            REG_H2:    cal.h2    = data[15:0];
            REG_H3:    cal.h3    = data[7:0];
            REG_H4_H5: cal.h4_h5 = data;
            REG_H6:    cal.h6    = data[7:0];
            default:   ;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    // drop s_valid and wait until every awaited item has come back
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (awaited.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_cal(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        apply_cal(idx, data);
    endtask

    task automatic offer_sample(input logic func, input logic [RAW_W-1:0] raw,
                                input logic fixed, input value_t fixed_value);
        reading_t want;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_func       <= func;
        s_raw_sample <= raw;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        want.kind = func;
        if (func == FUNC_TEMP) begin
            want.value = predict_temperature(raw, fine_t);
            temp_items++;
        end else begin
            want.value = predict_humidity(raw, fine_t);
            hum_items++;
        end
        if (fixed)
            want.value = fixed_value;
        awaited.push_back(want);
    endtask

    task automatic load_random_cal(input bit realistic);
        logic [CFG_DATA_W-1:0] vals [CAL_REGS];
        logic [CFG_IDX_W-1:0]  spare;
        if (realistic) begin
            vals[REG_T1]    = {8'h00, 16'($urandom_range(29000, 26000))};
            vals[REG_T2]    = {8'h00, 16'($urandom_range(27000, 25000))};
            vals[REG_T3]    = {8'h00, 16'hFFFF - 16'($urandom_range(1500, 200))};
            vals[REG_H1]    = {16'h0000, 8'($urandom_range(100, 0))};
            vals[REG_H2]    = {8'h00, 16'($urandom_range(420, 300))};
            vals[REG_H3]    = {16'h0000, 8'($urandom_range(10, 0))};
            vals[REG_H4_H5] = {12'($urandom_range(400, 250)), 12'($urandom_range(100, 0))};
            vals[REG_H6]    = {16'h0000, 8'($urandom_range(40, 20))};
        end else begin
            for (int r = 0; r < CAL_REGS; r++)
                vals[r] = CFG_DATA_W'($urandom());
        end
        spare = CFG_IDX_W'($urandom_range(REG_SPARE_HI, REG_SPARE_LO));
        wait_idle();
        for (int r = 0; r < CAL_REGS; r++)
            write_cal(CFG_IDX_W'(r), vals[r]);
        if ($urandom_range(1) == 1)
            write_cal(spare, CFG_DATA_W'($urandom()));
        cfg_valid <= 1'b0;
        cal_sets++;
    endtask

    initial begin : result_side
        reading_t want;
        int       hold_left;
        hold_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (awaited.size() == 0) begin
                    report_mismatch($sformatf("unexpected result kind %0d value %0d",
                                              m_kind, m_value));
                end else begin
                    want = awaited.pop_front();
                    checked_count++;
                    if (m_kind !== want.kind)
                        report_mismatch($sformatf("kind %0d, awaited %0d",
                                                  m_kind, want.kind));
                    if (m_value !== want.value)
                        report_mismatch($sformatf("kind %0d value %0d, awaited %0d",
                                                  want.kind, m_value, want.value));
                end
            end
            if (holds_served < hold_requests) begin
                hold_left = HOLD_OFF_CYCLES;
                holds_served++;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("No handshake for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, awaited.size());
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        script_row_t      row;
        bit               cal_open;
        bit               realistic;
        logic             f;
        logic [RAW_W-1:0] raw;
        s_valid      <= 1'b0;
        s_func       <= 1'b0;
        s_raw_sample <= '0;
        cfg_valid    <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        aresetn      <= 1'b0;
        cal      = '0;
        fine_t   = '0;
        cal_open = 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.op == ROW_CAL) begin
                if (!cal_open) begin
                    wait_idle();
                    cal_open = 1'b1;
                    cal_sets++;
                end
                write_cal(row.addr, row.data);
            end else begin
                if (cal_open) begin
                    cfg_valid <= 1'b0;
                    cal_open = 1'b0;
                end
                offer_sample(row.func, row.data[RAW_W-1:0], row.fixed, row.fixed_value);
            end
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            realistic = (phase % 3 != 2);
            load_random_cal(realistic);
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            if (phase == PRESSURE_PHASE)
                hold_requests++;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                f = 1'($urandom_range(1));
                if (!realistic || $urandom_range(99) < 20)
                    raw = RAW_W'($urandom());
                else if (f == FUNC_TEMP)
                    raw = RAW_W'($urandom_range(580000, 460000));
                else
                    raw = {4'($urandom()), 16'($urandom_range(45000, 15000))};
                offer_sample(f, raw, 1'b0, '0);
            end
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (awaited.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", awaited.size()));

        $display("Covered %0d temperature and %0d humidity items over %0d calibration sets,",
                 temp_items, hum_items, cal_sets);
        $display("with idling on both sides and one long output hold-off; %0d checked, %0d bad",
                 checked_count, mismatch_count);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
